// ===== src/ptca_pkg.sv =====
// Shared types and constants of the per-task cycle accounting block.
// Depends on nothing; ptca_front, ptca_back and the top level refer to it by scoped names.
`default_nettype none

package ptca_pkg;

    // Task table geometry.
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Depth of the queue between the front and back parts (a power of two).
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Event codes as they arrive on the mode field.
    localparam logic [2:0] MODE_RESET    = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_STOP     = 3'd2;
    localparam logic [2:0] MODE_SWITCH   = 3'd3;
    localparam logic [2:0] MODE_SNAPSHOT = 3'd4;
    localparam logic [2:0] MODE_GET      = 3'd5;

    // Internal operation codes after classification.
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP    = 3'd0;
    localparam op_t OP_RESET  = 3'd1;
    localparam op_t OP_START  = 3'd2;
    localparam op_t OP_STOP   = 3'd3;
    localparam op_t OP_SWITCH = 3'd4;
    localparam op_t OP_SNAP   = 3'd5;
    localparam op_t OP_GET    = 3'd6;

    // One classified event waiting in the queue.
    typedef struct packed {
        op_t                op;
        logic signed [15:0] task_id;
        logic [31:0]        time_now;
    } item_t;

    // Queue handshake between the front and back parts.
    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctrl_t;

endpackage

`default_nettype wire

// ===== src/ptca_if.sv =====
// Channel interfaces of the per-task cycle accounting block: event input and result output.
// Depends on nothing.
`default_nettype none

interface ptca_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [15:0] task_id;
    logic [31:0]        time_now;

    modport source (output valid, output mode, output task_id, output time_now, input ready);
    modport sink (input valid, input mode, input task_id, input time_now, output ready);
endinterface

interface ptca_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] task_cyc;
    logic [63:0] total_cyc;
    logic        table_overflow;

    modport source (output valid, output found, output task_cyc, output total_cyc,
                    output table_overflow, input ready);
    modport sink (input valid, input found, input task_cyc, input total_cyc,
                  input table_overflow, output ready);
endinterface

`default_nettype wire

// ===== src/ptca_front.sv =====
// Front part: accepts event transactions, classifies the mode and queues them.
// Depends on ptca_pkg and ptca_if.
`default_nettype none

module ptca_front (
    input  wire              clk,
    input  wire              rst_n,
    ptca_evt_if.sink         evt,
    output ptca_pkg::item_t  head,
    input  wire              pop,
    output logic             head_valid
);

    ptca_pkg::item_t           fifo_reg [ptca_pkg::QDEPTH];
    logic [ptca_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ptca_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ptca_pkg::QPTR_W:0]   count_reg;
    ptca_pkg::item_t           classified;
    logic                      push;
    logic                      do_pop;

    // Map the external mode onto an internal operation.
    always_comb
    begin
        classified.task_id  = evt.task_id;
        classified.time_now = evt.time_now;
        case (evt.mode)
            ptca_pkg::MODE_RESET:    classified.op = ptca_pkg::OP_RESET;
            ptca_pkg::MODE_START:    classified.op = ptca_pkg::OP_START;
            ptca_pkg::MODE_STOP:     classified.op = ptca_pkg::OP_STOP;
            ptca_pkg::MODE_SWITCH:   classified.op = ptca_pkg::OP_SWITCH;
            ptca_pkg::MODE_SNAPSHOT: classified.op = ptca_pkg::OP_SNAP;
            ptca_pkg::MODE_GET:      classified.op = ptca_pkg::OP_GET;
            default:                 classified.op = ptca_pkg::OP_NOP;
        endcase
    end

    assign evt.ready  = (count_reg != (ptca_pkg::QPTR_W+1)'(ptca_pkg::QDEPTH));
    assign push       = evt.valid && evt.ready;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = fifo_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= classified;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ptca_back.sv =====
// Back part: executes one queued event at a time against the task table and drives results.
// Depends on ptca_pkg and ptca_if.
`default_nettype none

module ptca_back (
    input  wire              clk,
    input  wire              rst_n,
    input  ptca_pkg::item_t  head,
    input  wire              head_valid,
    output logic             pop,
    ptca_res_if.source       res
);

    localparam int IW = ptca_pkg::IDX_W;
    localparam int N  = ptca_pkg::TABLE_ENTRIES;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_FOLD_WR = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_GET_RD  = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    // Table memories; entries are meaningful only where the used bit is set.
    logic [15:0] task_mem [N];
    logic [63:0] cyc_mem [N];

    logic [2:0]      state_reg, state_next;
    ptca_pkg::item_t work_reg, work_next;
    logic [N-1:0]    used_reg, used_next;
    logic            cur_valid_reg, cur_valid_next;
    logic [IW-1:0]   cur_slot_reg, cur_slot_next;
    logic [31:0]     last_time_reg, last_time_next;
    logic [63:0]     grand_reg, grand_next;
    logic            time_ready_reg, time_ready_next;
    logic            overflow_reg, overflow_next;
    logic [31:0]     delta_reg, delta_next;
    logic            slot_fold_reg, slot_fold_next;
    logic [IW-1:0]   scan_idx_reg, scan_idx_next;
    logic            issue_done_reg, issue_done_next;
    logic [IW-1:0]   cmp_idx_reg;
    logic            cmp_vld_reg;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    logic            found_reg, found_next;
    logic [63:0]     task_cyc_reg, task_cyc_next;
    logic [15:0]     task_rd_reg;
    logic [63:0]     cyc_rd_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg;
    logic [63:0]     out_task_cyc_reg;
    logic [63:0]     out_total_reg;
    logic            out_overflow_reg;
    logic            out_load;

    logic            task_we;
    logic [IW-1:0]   task_waddr;
    logic            cyc_we;
    logic [IW-1:0]   cyc_waddr;
    logic [63:0]     cyc_wdata;
    logic [IW-1:0]   cyc_raddr;

    logic [31:0]     delta;
    logic            negative;
    logic            cmp_used;
    logic            cmp_hit;
    logic            cmp_free_here;
    logic            cmp_last;
    logic            alloc_ok;
    logic [IW-1:0]   alloc_idx;

    assign delta         = work_reg.time_now - last_time_reg;
    assign negative      = work_reg.task_id[15];
    assign cmp_used      = used_reg[cmp_idx_reg];
    assign cmp_hit       = cmp_vld_reg && cmp_used && (task_rd_reg == $unsigned(work_reg.task_id));
    assign cmp_free_here = cmp_vld_reg && !cmp_used;
    assign cmp_last      = cmp_vld_reg && (cmp_idx_reg == ptca_pkg::LAST_IDX);
    assign alloc_ok      = free_found_reg || cmp_free_here;
    assign alloc_idx     = free_found_reg ? free_idx_reg : cmp_idx_reg;
    assign cyc_raddr     = (state_reg == S_SCAN) ? cmp_idx_reg : cur_slot_reg;

    // Table memories: one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (task_we)
        begin
            task_mem[task_waddr] <= $unsigned(work_reg.task_id);
        end
        task_rd_reg <= task_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cyc_we)
        begin
            cyc_mem[cyc_waddr] <= cyc_wdata;
        end
        cyc_rd_reg <= cyc_mem[cyc_raddr];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        work_next        = work_reg;
        used_next        = used_reg;
        cur_valid_next   = cur_valid_reg;
        cur_slot_next    = cur_slot_reg;
        last_time_next   = last_time_reg;
        grand_next       = grand_reg;
        time_ready_next  = time_ready_reg;
        overflow_next    = overflow_reg;
        delta_next       = delta_reg;
        slot_fold_next   = slot_fold_reg;
        scan_idx_next    = scan_idx_reg;
        issue_done_next  = issue_done_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        found_next       = found_reg;
        task_cyc_next    = task_cyc_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_load         = 1'b0;
        pop              = 1'b0;
        task_we          = 1'b0;
        task_waddr       = cmp_idx_reg;
        cyc_we           = 1'b0;
        cyc_waddr        = cmp_idx_reg;
        cyc_wdata        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    work_next  = head;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                scan_idx_next    = '0;
                issue_done_next  = 1'b0;
                free_found_next  = 1'b0;
                found_next       = 1'b0;
                task_cyc_next    = '0;
                case (work_reg.op)
                    ptca_pkg::OP_RESET:
                    begin
                        // After clearing, the first slot is the one allocated, if the task id is non-negative.
                        used_next       = '0;
                        grand_next      = '0;
                        overflow_next   = 1'b0;
                        last_time_next  = work_reg.time_now;
                        time_ready_next = 1'b1;
                        cur_slot_next   = '0;
                        cur_valid_next  = !negative;
                        if (!negative)
                        begin
                            used_next[0] = 1'b1;
                            task_we      = 1'b1;
                            task_waddr   = '0;
                            cyc_we       = 1'b1;
                            cyc_waddr    = '0;
                        end
                        state_next = S_RESULT;
                    end
                    ptca_pkg::OP_START, ptca_pkg::OP_STOP, ptca_pkg::OP_GET:
                    begin
                        state_next = S_SCAN;
                    end
                    ptca_pkg::OP_SWITCH, ptca_pkg::OP_SNAP:
                    begin
                        // Fold; the current slot's count is read here and written next.
                        last_time_next  = work_reg.time_now;
                        time_ready_next = 1'b1;
                        delta_next      = delta;
                        slot_fold_next  = time_ready_reg && cur_valid_reg;
                        if (time_ready_reg)
                        begin
                            grand_next = grand_reg + {32'h0, delta};
                        end
                        state_next = S_FOLD_WR;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_FOLD_WR:
            begin
                if (slot_fold_reg)
                begin
                    cyc_we    = 1'b1;
                    cyc_waddr = cur_slot_reg;
                    cyc_wdata = cyc_rd_reg + {32'h0, delta_reg};
                end
                if (work_reg.op == ptca_pkg::OP_SNAP)
                begin
                    state_next = S_RESULT;
                end
                else if (negative)
                begin
                    cur_valid_next = 1'b0;
                    cur_slot_next  = '0;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue side: one table read per cycle.
                if (!issue_done_reg)
                begin
                    if (scan_idx_reg == ptca_pkg::LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                // Compare side: remember the lowest free slot.
                if (cmp_free_here && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (cmp_hit || cmp_last)
                begin
                    state_next = S_RESULT;
                    case (work_reg.op)
                        ptca_pkg::OP_START, ptca_pkg::OP_SWITCH:
                        begin
                            if (cmp_hit)
                            begin
                                if (work_reg.op == ptca_pkg::OP_START)
                                begin
                                    cyc_we = 1'b1;
                                end
                                cur_valid_next = (work_reg.op == ptca_pkg::OP_SWITCH)
                                                 ? 1'b1 : cur_valid_reg;
                                cur_slot_next  = (work_reg.op == ptca_pkg::OP_SWITCH)
                                                 ? cmp_idx_reg : cur_slot_reg;
                            end
                            else if (alloc_ok)
                            begin
                                used_next[alloc_idx] = 1'b1;
                                task_we              = 1'b1;
                                task_waddr           = alloc_idx;
                                cyc_we               = 1'b1;
                                cyc_waddr            = alloc_idx;
                                if (work_reg.op == ptca_pkg::OP_SWITCH)
                                begin
                                    cur_valid_next = 1'b1;
                                    cur_slot_next  = alloc_idx;
                                end
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                                if (work_reg.op == ptca_pkg::OP_SWITCH)
                                begin
                                    cur_valid_next = 1'b0;
                                    cur_slot_next  = '0;
                                end
                            end
                        end
                        ptca_pkg::OP_STOP:
                        begin
                            if (cmp_hit)
                            begin
                                // The slot is freed; if it is the current slot, only the grand total is charged.
                                if (cur_valid_reg && (cur_slot_reg == cmp_idx_reg))
                                begin
                                    last_time_next  = work_reg.time_now;
                                    time_ready_next = 1'b1;
                                    if (time_ready_reg)
                                    begin
                                        grand_next = grand_reg + {32'h0, delta};
                                    end
                                    cur_valid_next = 1'b0;
                                    cur_slot_next  = '0;
                                end
                                used_next[cmp_idx_reg] = 1'b0;
                            end
                        end
                        ptca_pkg::OP_GET:
                        begin
                            if (cmp_hit)
                            begin
                                found_next = 1'b1;
                                state_next = S_GET_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_GET_RD:
            begin
                task_cyc_next = cyc_rd_reg;
                state_next    = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            cur_valid_reg  <= 1'b0;
            cur_slot_reg   <= '0;
            last_time_reg  <= '0;
            grand_reg      <= '0;
            time_ready_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            cur_valid_reg  <= cur_valid_next;
            cur_slot_reg   <= cur_slot_next;
            last_time_reg  <= last_time_next;
            grand_reg      <= grand_next;
            time_ready_reg <= time_ready_next;
            overflow_reg   <= overflow_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= (state_reg == S_SCAN) && !issue_done_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        delta_reg       <= delta_next;
        slot_fold_reg   <= slot_fold_next;
        cmp_idx_reg     <= scan_idx_reg;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        found_reg       <= found_next;
        task_cyc_reg    <= task_cyc_next;
        if (out_load)
        begin
            out_found_reg    <= found_reg;
            out_task_cyc_reg <= task_cyc_reg;
            out_total_reg    <= grand_reg;
            out_overflow_reg <= overflow_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.found          = out_found_reg;
    assign res.task_cyc       = out_task_cyc_reg;
    assign res.total_cyc      = out_total_reg;
    assign res.table_overflow = out_overflow_reg;

endmodule

`default_nettype wire

// ===== src/per_task_cycle_accounting.sv =====
// Top level of the per-task cycle accounting block: front queue, back sequencer, checks.
// Depends on ptca_pkg, ptca_if, ptca_front and ptca_back.
`default_nettype none

// Keeps cycle counts for up to TABLE_ENTRIES tasks plus a running total. Each event
// transaction (reset, start, stop, switch, snapshot, get) returns exactly one result
// transaction carrying the lookup result of a get, the grand total and the sticky
// table-full flag. Events enter a two-entry queue and are executed one at a time by
// a sequencer that scans the task table one slot per cycle through the memory's read
// port. Start, stop, get and switch scan the table, ending early on a hit (a switch
// to a negative task id skips the scan); a switch first folds the elapsed time, and
// a get that hits then reads its count. Reset, snapshot and unused modes do not scan.
// The result sits in an output register, so the queue keeps accepting events while a
// result waits to be taken.
module per_task_cycle_accounting (
    input  wire        clk,
    input  wire        rst_n,
    ptca_evt_if.sink   evt,
    ptca_res_if.source res
);

    ptca_pkg::item_t q_head;
    ptca_pkg::q_ctrl_t q_ctrl;

    ptca_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .head       (q_head),
        .pop        (q_ctrl.pop),
        .head_valid (q_ctrl.valid)
    );

    ptca_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_ctrl.valid),
        .pop        (q_ctrl.pop),
        .res        (res)
    );

    // The back part only takes an item from a non-empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_ctrl.pop |-> q_ctrl.valid)
        else $error("queue popped while empty");

    // The back part leaves its idle state on each pop, so pops never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n) q_ctrl.pop |=> !q_ctrl.pop)
        else $error("back part popped two items in consecutive cycles");

    // A pop is always followed by execution, never by an immediate result.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.pop && !res.valid |=> !res.valid)
        else $error("result appeared one cycle after a pop");

endmodule

`default_nettype wire
